[rtl/core/motor_speed_ramp_hbridge_pwm_unit_macros.svh]
// Assertion macros for the motor speed ramp H-bridge PWM unit.
// Used by the port checker; expects clk and rst_n in the using scope.
`ifndef MOTOR_SPEED_RAMP_HBRIDGE_PWM_UNIT_MACROS_SVH
`define MOTOR_SPEED_RAMP_HBRIDGE_PWM_UNIT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define MSHP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define MSHP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/mshp_pkg.sv]
// Shared constants, codes and controller/datapath command types.
// No dependencies.
`default_nettype none

package mshp_pkg;

    localparam int unsigned DUTY_BITS_DEF = 16;

    localparam int unsigned TOP_W  = 16;
    localparam int unsigned STEP_W = 7;
    localparam int unsigned PCT_W  = 7;
    localparam int unsigned DIR_W  = 2;
    localparam int unsigned TGT_W  = 8;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 1'd1;

    localparam logic [TOP_W-1:0]  PWM_TOP_RST   = 16'd999;
    localparam logic [STEP_W-1:0] RAMP_STEP_RST = 7'd5;

    // direction codes
    localparam logic [DIR_W-1:0] DIR_FWD   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_BWD   = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BRAKE = 2'd2;
    localparam logic [DIR_W-1:0] DIR_COAST = 2'd3;

    localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
    localparam logic [TGT_W-1:0]  TGT_FULL     = 8'd100;
    localparam logic [STEP_W-1:0] STEP_MIN     = 7'd4;

    // x/100 == (x*DIV_MAGIC)>>DIV_SHIFT, exact for x < 2^23
    localparam int unsigned PROD_W    = 23;
    localparam int unsigned DIV_SHIFT = 30;
    localparam int unsigned QUOT_W    = 17;
    localparam logic [23:0] DIV_MAGIC = 24'd10737419;

    typedef struct packed {
        logic load;         // latch accepted command
        logic set_dir;      // dir_now <= commanded direction
        logic step_down;    // speed toward zero
        logic step_toward;  // speed toward target
        logic step_stop;    // zero-speed result, clear speed
        logic mul1;         // pct * (top + 1)
        logic mul2;         // reciprocal multiply for /100
        logic emit;         // load output register
        logic last;         // last flag for emitted word
    } dp_cmd_t;

    typedef struct packed {
        logic cur_zero;
        logic at_target;
        logic tgt_zero;
        logic stop_dir;     // commanded brake or coast
        logic dir_differs;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/mshp_ifs.sv]
// Valid/ready channel interfaces: command word in, result word out.
// Depends on mshp_pkg.
`default_nettype none

interface mshp_cmd_if import mshp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DIR_W-1:0] direction;
    logic [TGT_W-1:0] speed_target;

    modport source (output valid, output direction, output speed_target, input ready);
    modport sink   (input valid, input direction, input speed_target, output ready);
endinterface

interface mshp_res_if import mshp_pkg::*; #(
    parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) ();
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] duty_ch1;
    logic [DUTY_BITS-1:0] duty_ch2;
    logic [PCT_W-1:0]     speed_now;
    logic                 last;

    modport source (output valid, output duty_ch1, output duty_ch2, output speed_now,
                    output last, input ready);
    modport sink   (input valid, input duty_ch1, input duty_ch2, input speed_now,
                    input last, output ready);
endinterface

`default_nettype wire

[rtl/core/motor_speed_ramp_hbridge_pwm_unit.sv]
// Top level: DC motor soft-start ramp with H-bridge compare outputs.
// Depends on mshp_pkg, mshp_ifs, mshp_ctl, mshp_dp.
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+------------
//  cmd     | in  | direction[1:0], speed_target[7:0]        | valid/ready
//  res     | out | duty_ch1, duty_ch2, speed_now[6:0], last | valid/ready
//  cfg     | in  | cfg_we, cfg_index[0], cfg_data[15:0]     | write only
//
// A command word passes accept and decide, then step, two multiply stages
// and emit for each result word; up to 51 result words. cmd.ready is
// high only while the sequencer is idle. A stalled res.ready holds the
// sequencer in emit. No clearing pass at reset.
`default_nettype none

module motor_speed_ramp_hbridge_pwm_unit import mshp_pkg::*; #(
    parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    mshp_cmd_if.sink                   cmd,
    mshp_res_if.source                 res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  dp_cmd;     // sequencer -> datapath
    dp_stat_t dp_stat;    // datapath -> sequencer
    logic     in_ready;

    assign cmd.ready = in_ready;

    // sequencer: walks down / toward / stop phases
    mshp_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (in_ready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    // datapath: state, step math, duty multiply, output word register
    mshp_dp #(
        .DUTY_BITS (DUTY_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .direction    (cmd.direction),
        .speed_target (cmd.speed_target),
        .cmd          (dp_cmd),
        .stat         (dp_stat),
        .res_ready    (res.ready),
        .res_valid    (res.valid),
        .duty_ch1     (res.duty_ch1),
        .duty_ch2     (res.duty_ch2),
        .speed_now    (res.speed_now),
        .last         (res.last)
    );

endmodule

`default_nettype wire

[rtl/core/mshp_ctl.sv]
// Ramp sequencer: walks down/toward/stop phases, one result per pass.
// Depends on mshp_pkg.
`default_nettype none

module mshp_ctl import mshp_pkg::*; (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_STEP,
        S_MUL1,
        S_MUL2,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_DOWN,
        PH_TOWARD,
        PH_STOP
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   last_w;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (phase_reg)
            PH_DOWN:   last_w = stat.cur_zero && stat.tgt_zero && !stat.stop_dir;
            PH_TOWARD: last_w = stat.at_target && !stat.stop_dir;
            PH_STOP:   last_w = 1'b1;
            default:   last_w = 1'b1;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (stat.dir_differs && !stat.cur_zero)
                begin
                    phase_next = PH_DOWN;
                    state_next = S_STEP;
                end
                else
                begin
                    cmd.set_dir = 1'b1;
                    if (!stat.at_target)
                    begin
                        phase_next = PH_TOWARD;
                        state_next = S_STEP;
                    end
                    else if (stat.stop_dir)
                    begin
                        phase_next = PH_STOP;
                        state_next = S_STEP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STEP:
            begin
                unique case (phase_reg)
                    PH_DOWN:   cmd.step_down   = 1'b1;
                    PH_TOWARD: cmd.step_toward = 1'b1;
                    PH_STOP:   cmd.step_stop   = 1'b1;
                    default:   cmd.step_stop   = 1'b1;
                endcase
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = last_w;
                    if (last_w)
                    begin
                        if (phase_reg == PH_DOWN)
                            cmd.set_dir = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_STEP;
                        unique case (phase_reg)
                            PH_DOWN:
                            begin
                                if (stat.cur_zero)
                                begin
                                    cmd.set_dir = 1'b1;
                                    phase_next  = stat.tgt_zero ? PH_STOP : PH_TOWARD;
                                end
                            end
                            PH_TOWARD:
                            begin
                                if (stat.at_target)
                                    phase_next = PH_STOP;
                            end
                            default: phase_next = phase_reg;
                        endcase
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_TOWARD;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mshp_dp.sv]
// Datapath: config registers, speed/direction state, step arithmetic,
// two-stage duty multiply (/100 by reciprocal) and output register.
// Depends on mshp_pkg.
`default_nettype none

module mshp_dp import mshp_pkg::*; #(
    parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [DIR_W-1:0]      direction,
    input  wire logic [TGT_W-1:0]      speed_target,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic                  res_ready,
    output logic                       res_valid,
    output logic [DUTY_BITS-1:0]       duty_ch1,
    output logic [DUTY_BITS-1:0]       duty_ch2,
    output logic [PCT_W-1:0]           speed_now,
    output logic                       last
);

    logic [TOP_W-1:0]     pwm_top_reg;
    logic [STEP_W-1:0]    ramp_step_reg;
    logic [PCT_W-1:0]     cur_reg;
    logic [DIR_W-1:0]     dir_now_reg;
    logic [DIR_W-1:0]     dir_cmd_reg;
    logic [PCT_W-1:0]     tgt_reg;
    logic [PCT_W-1:0]     res_pct_reg;
    logic [DIR_W-1:0]     res_dir_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic                 out_valid_reg;
    logic [DUTY_BITS-1:0] ch1_reg;
    logic [DUTY_BITS-1:0] ch2_reg;
    logic [PCT_W-1:0]     spd_reg;
    logic                 last_reg;

    logic [STEP_W-1:0]    step_eff;
    logic [PCT_W-1:0]     dn_pct;
    logic [PCT_W:0]       up_sum;
    logic [PCT_W-1:0]     up_pct;
    logic [PCT_W-1:0]     tw_pct;
    logic [23:0]          prod_full;
    logic [46:0]          quot_full;
    logic [TOP_W-1:0]     duty16;
    logic [TOP_W-1:0]     c1;
    logic [TOP_W-1:0]     c2;
    logic [31:0]          c1_ext;
    logic [31:0]          c2_ext;

    // step arithmetic
    always_comb
    begin
        step_eff = (ramp_step_reg < STEP_MIN) ? STEP_MIN : ramp_step_reg;
        dn_pct   = (cur_reg >= step_eff) ? (cur_reg - step_eff) : '0;
        up_sum   = {1'b0, cur_reg} + {1'b0, step_eff};
        up_pct   = (up_sum > {1'b0, tgt_reg}) ? tgt_reg : up_sum[PCT_W-1:0];
        if (cur_reg < tgt_reg)
            tw_pct = up_pct;
        else
            tw_pct = (dn_pct < tgt_reg) ? tgt_reg : dn_pct;
    end

    // duty multiply chain
    assign prod_full = 24'(res_pct_reg) * 24'({1'b0, pwm_top_reg} + 17'd1);
    assign quot_full = 47'(prod_reg) * 47'(DIV_MAGIC);

    always_comb
    begin
        duty16 = (quot_reg > {1'b0, pwm_top_reg}) ? pwm_top_reg : quot_reg[TOP_W-1:0];
        c1 = '0;
        c2 = '0;
        unique case (res_dir_reg)
            DIR_FWD:   c1 = duty16;
            DIR_BWD:   c2 = duty16;
            DIR_BRAKE:
            begin
                c1 = pwm_top_reg;
                c2 = pwm_top_reg;
            end
            DIR_COAST: c1 = '0;
            default:   c1 = '0;
        endcase
        c1_ext = {16'b0, c1};
        c2_ext = {16'b0, c2};
    end

    assign stat.cur_zero    = (cur_reg == '0);
    assign stat.at_target   = (cur_reg == tgt_reg);
    assign stat.tgt_zero    = (tgt_reg == '0);
    assign stat.stop_dir    = (dir_cmd_reg == DIR_BRAKE) || (dir_cmd_reg == DIR_COAST);
    assign stat.dir_differs = (dir_cmd_reg != dir_now_reg);
    assign stat.out_free    = !out_valid_reg || res_ready;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_top_reg   <= PWM_TOP_RST;
            ramp_step_reg <= RAMP_STEP_RST;
            cur_reg       <= '0;
            dir_now_reg   <= DIR_COAST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_PWM_TOP:   pwm_top_reg   <= cfg_data[TOP_W-1:0];
                    CFG_RAMP_STEP: ramp_step_reg <= cfg_data[STEP_W-1:0];
                    default:       pwm_top_reg   <= pwm_top_reg;
                endcase
            end
            if (cmd.set_dir)
                dir_now_reg <= dir_cmd_reg;
            if (cmd.step_down)
                cur_reg <= dn_pct;
            else if (cmd.step_toward)
                cur_reg <= tw_pct;
            else if (cmd.step_stop)
                cur_reg <= '0;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dir_cmd_reg <= direction;
            tgt_reg     <= (speed_target > TGT_FULL) ? PCT_FULL : speed_target[PCT_W-1:0];
        end
        if (cmd.step_down || cmd.step_toward || cmd.step_stop)
        begin
            res_dir_reg <= dir_now_reg;
            res_pct_reg <= cmd.step_down ? dn_pct : (cmd.step_toward ? tw_pct : '0);
        end
        if (cmd.mul1)
            prod_reg <= prod_full[PROD_W-1:0];
        if (cmd.mul2)
            quot_reg <= quot_full[DIV_SHIFT +: QUOT_W];
        if (cmd.emit)
        begin
            ch1_reg  <= c1_ext[DUTY_BITS-1:0];
            ch2_reg  <= c2_ext[DUTY_BITS-1:0];
            spd_reg  <= res_pct_reg;
            last_reg <= cmd.last;
        end
    end

    assign res_valid = out_valid_reg;
    assign duty_ch1  = ch1_reg;
    assign duty_ch2  = ch2_reg;
    assign speed_now = spd_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[rtl/core/mshp_chk.sv]
// Port-level checker for the ramp PWM unit, bound to the top level.
// Depends on mshp_pkg and motor_speed_ramp_hbridge_pwm_unit_macros.svh.
`default_nettype none

`include "motor_speed_ramp_hbridge_pwm_unit_macros.svh"

module mshp_chk import mshp_pkg::*; #(
    parameter int unsigned DUTY_BITS = DUTY_BITS_DEF
) (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 cmd_valid,
    input wire logic                 cmd_ready,
    input wire logic                 res_valid,
    input wire logic                 res_ready,
    input wire logic [DUTY_BITS-1:0] res_ch1,
    input wire logic [DUTY_BITS-1:0] res_ch2,
    input wire logic [PCT_W-1:0]     res_speed,
    input wire logic                 res_last
);

    logic                         res_stall;
    logic [2*DUTY_BITS+PCT_W:0]   res_word;
    logic                         bridge_ok;

    assign res_stall = res_valid && !res_ready;
    assign res_word  = {res_ch1, res_ch2, res_speed, res_last};
    // one side off, or both at the same level (brake)
    assign bridge_ok = (res_ch1 == '0) || (res_ch2 == '0) || (res_ch1 == res_ch2);

    `MSHP_ASSERT_NXT(a_res_hold, res_stall, res_valid && $stable(res_word), "word changed in stall")
    `MSHP_ASSERT_IMP(a_speed_max, res_valid, res_speed <= PCT_FULL, "speed_now above 100")
    `MSHP_ASSERT_IMP(a_idle_mid_run, res_valid && !res_last, !cmd_ready, "command taken mid-run")
    `MSHP_ASSERT_IMP(a_bridge_ok, res_valid, bridge_ok, "both bridge sides driven unequal")
    `MSHP_ASSERT_NXT(a_busy_after, cmd_valid && cmd_ready, !cmd_ready, "ready held after accept")

endmodule

bind motor_speed_ramp_hbridge_pwm_unit mshp_chk #(
    .DUTY_BITS (DUTY_BITS)
) u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_ch1   (res.duty_ch1),
    .res_ch2   (res.duty_ch2),
    .res_speed (res.speed_now),
    .res_last  (res.last)
);

`default_nettype wire
